@@ sv/bio_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bio_pkg;

   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_SWITCH = 2'd2,
      CMD_BUTTON = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEG_MODE_LOW  = 2'd0,
      SEG_MODE_HIGH = 2'd1,
      SEG_MODE_RAW  = 2'd2
   } seg_mode_type;

   localparam logic [4:0] OFF_LEDS     = 5'h00;
   localparam logic [4:0] OFF_SWITCHES = 5'h04;
   localparam logic [4:0] OFF_BTN_CTL  = 5'h08;
   localparam logic [4:0] OFF_SEGS     = 5'h0c;
   localparam logic [4:0] OFF_SEG_CTL  = 5'h10;

   localparam logic [31:0] SEG_RESET = 32'h3F3F_3F3F;

   typedef struct packed {
      cmd_type     cmd;
      logic [4:0]  reg_offset;
      logic [31:0] write_data;
      logic [2:0]  element_index;
      logic        pressed;
   } req_type;

   typedef struct packed {
      logic [11:0] read_data;
      logic [7:0]  led_lines;
      logic [31:0] segment_lines;
      logic        irq_line;
   } rsp_type;

   typedef struct packed {
      logic [11:0] read_data;
      logic [7:0]  led_lines;
      logic        irq_line;
   } snap_type;

   typedef struct packed {
      snap_type    snap;
      logic        seg_wr;
      logic        raw;
      logic [15:0] value;
   } entry_type;

   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] g;
      case (d)
         4'h0: g = 8'h3F;
         4'h1: g = 8'h06;
         4'h2: g = 8'h5B;
         4'h3: g = 8'h4F;
         4'h4: g = 8'h66;
         4'h5: g = 8'h6D;
         4'h6: g = 8'h7D;
         4'h7: g = 8'h07;
         4'h8: g = 8'h7F;
         4'h9: g = 8'h6F;
         4'hA: g = 8'h77;
         4'hB: g = 8'h7C;
         4'hC: g = 8'h39;
         4'hD: g = 8'h5E;
         4'hE: g = 8'h79;
         default: g = 8'h71;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

@@ sv/bio_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bio_regs (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire bio_pkg::req_type   req,
   output bio_pkg::entry_type      entry
);

   logic [7:0]            led_ff, led_in;
   logic [7:0]            sw_ff, sw_in;
   logic [3:0]            btn_ff, btn_in;
   bio_pkg::seg_mode_type seg_mode_ff, seg_mode_in;
   logic                  irq_mode_ff, irq_mode_in;
   logic                  irq_ff, irq_in;
   logic [11:0]           rd;
   logic                  seg_wr;

   always_comb begin
      led_in      = led_ff;
      sw_in       = sw_ff;
      btn_in      = btn_ff;
      seg_mode_in = seg_mode_ff;
      irq_mode_in = irq_mode_ff;
      irq_in      = irq_ff;
      rd          = '0;
      seg_wr      = 1'b0;
      case (req.cmd)
         bio_pkg::CMD_READ: begin
            if (req.reg_offset == bio_pkg::OFF_SWITCHES) begin
               rd = {btn_ff, sw_ff};
               if (irq_mode_ff) begin
                  btn_in = '0;
                  irq_in = 1'b0;
               end
            end
         end
         bio_pkg::CMD_WRITE: begin
            case (req.reg_offset)
               bio_pkg::OFF_LEDS: led_in = req.write_data[7:0];
               bio_pkg::OFF_SEGS: seg_wr = 1'b1;
               bio_pkg::OFF_SEG_CTL: begin
                  if (req.write_data <= 32'(bio_pkg::SEG_MODE_RAW)) begin
                     seg_mode_in = bio_pkg::seg_mode_type'(req.write_data[1:0]);
                  end
               end
               bio_pkg::OFF_BTN_CTL: begin
                  if (req.write_data <= 32'd1) begin
                     irq_mode_in = req.write_data[0];
                     irq_in      = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         bio_pkg::CMD_SWITCH: begin
            if (req.pressed) begin
               sw_in = sw_ff ^ (8'd1 << req.element_index);
            end
         end
         bio_pkg::CMD_BUTTON: begin
            if (!req.element_index[2]) begin
               if (!irq_mode_ff) begin
                  btn_in[req.element_index[1:0]] = req.pressed;
               end else if (req.pressed) begin
                  btn_in[req.element_index[1:0]] = 1'b1;
                  irq_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      entry.snap.read_data = rd;
      entry.snap.led_lines = led_in;
      entry.snap.irq_line  = irq_in;
      entry.seg_wr         = seg_wr;
      case (seg_mode_ff)
         bio_pkg::SEG_MODE_LOW: begin
            entry.raw   = 1'b0;
            entry.value = req.write_data[15:0];
         end
         bio_pkg::SEG_MODE_HIGH: begin
            entry.raw   = 1'b0;
            entry.value = req.write_data[31:16];
         end
         bio_pkg::SEG_MODE_RAW: begin
            entry.raw   = 1'b1;
            entry.value = req.write_data[15:0];
         end
         default: begin
            entry.raw   = 1'b1;
            entry.value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff      <= '0;
         sw_ff       <= '0;
         btn_ff      <= '0;
         seg_mode_ff <= bio_pkg::SEG_MODE_LOW;
         irq_mode_ff <= 1'b0;
         irq_ff      <= 1'b0;
      end else if (accept) begin
         led_ff      <= led_in;
         sw_ff       <= sw_in;
         btn_ff      <= btn_in;
         seg_mode_ff <= seg_mode_in;
         irq_mode_ff <= irq_mode_in;
         irq_ff      <= irq_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/bio_seg_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bio_seg_pipe (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire bio_pkg::entry_type  entry,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output bio_pkg::rsp_type         out_data
);

   // x / 100 == (x * 83887) >> 23 for every 16-bit x
   localparam logic [32:0] RECIP_100 = 33'd83887;
   localparam int          RECIP_SHIFT = 23;

   typedef struct packed {
      bio_pkg::snap_type snap;
      logic              seg_wr;
      logic              raw;
      logic [15:0]       value;
      logic [9:0]        q;
   } s2_type;

   typedef struct packed {
      bio_pkg::snap_type snap;
      logic              seg_wr;
      logic              raw;
      logic [15:0]       value;
      logic [6:0]        r_lo;
      logic [6:0]        r_hi;
   } s3_type;

   typedef struct packed {
      bio_pkg::snap_type snap;
      logic              seg_wr;
      logic [15:0]       digits;
   } s4_type;

   // two decimal digits of r < 100: r / 10 == (r * 205) >> 11
   function automatic logic [7:0] split_dec(input logic [6:0] r);
      logic [14:0] p;
      logic [3:0]  t;
      logic [6:0]  u;
      p = 15'(r) * 15'd205;
      t = p[14:11];
      u = r - 7'(7'(t) * 7'd10);
      return {t, u[3:0]};
   endfunction

   bio_pkg::entry_type s1_ff;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   bio_pkg::rsp_type   rsp_ff, rsp_in;
   logic [31:0]        seg_ff, seg_in;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic               s1_free, s2_free, s3_free, s4_free, out_free;
   logic [32:0]        q_prod;
   logic [15:0]        r_lo_full;
   logic [2:0]         hundreds;
   logic [31:0]        pattern;

   assign out_free = !rsp_valid_ff || out_ready;
   assign s4_free  = !s4_valid_ff || out_free;
   assign s3_free  = !s3_valid_ff || s4_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_ready = s1_free;

   assign q_prod = 33'(s1_ff.value) * RECIP_100;

   always_comb begin
      s2_in.snap   = s1_ff.snap;
      s2_in.seg_wr = s1_ff.seg_wr;
      s2_in.raw    = s1_ff.raw;
      s2_in.value  = s1_ff.value;
      s2_in.q      = q_prod[RECIP_SHIFT +: 10];
   end

   always_comb begin
      hundreds = '0;
      for (int k = 1; k <= 6; k++) begin
         if (s2_ff.q >= 10'(k * 100)) begin
            hundreds = 3'(k);
         end
      end
      r_lo_full    = s2_ff.value - 16'(16'(s2_ff.q) * 16'd100);
      s3_in.snap   = s2_ff.snap;
      s3_in.seg_wr = s2_ff.seg_wr;
      s3_in.raw    = s2_ff.raw;
      s3_in.value  = s2_ff.value;
      s3_in.r_lo   = r_lo_full[6:0];
      s3_in.r_hi   = 7'(s2_ff.q - 10'(10'(hundreds) * 10'd100));
   end

   always_comb begin
      s4_in.snap   = s3_ff.snap;
      s4_in.seg_wr = s3_ff.seg_wr;
      s4_in.digits = s3_ff.raw ? {split_dec(s3_ff.r_hi), split_dec(s3_ff.r_lo)}
                               : s3_ff.value;
   end

   always_comb begin
      pattern = {bio_pkg::glyph(s4_ff.digits[15:12]), bio_pkg::glyph(s4_ff.digits[11:8]),
                 bio_pkg::glyph(s4_ff.digits[7:4]),   bio_pkg::glyph(s4_ff.digits[3:0])};
      seg_in  = s4_ff.seg_wr ? pattern : seg_ff;
      rsp_in.read_data     = s4_ff.snap.read_data;
      rsp_in.led_lines     = s4_ff.snap.led_lines;
      rsp_in.irq_line      = s4_ff.snap.irq_line;
      rsp_in.segment_lines = seg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seg_ff       <= bio_pkg::SEG_RESET;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s4_valid_ff;
            if (s4_valid_ff) begin
               seg_ff <= seg_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ff <= entry;
      end
      if (s2_free) begin
         s2_ff <= s2_in;
      end
      if (s3_free) begin
         s3_ff <= s3_in;
      end
      if (s4_free) begin
         s4_ff <= s4_in;
      end
      if (out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

@@ sv/board_io_panel_registers.sv @@
`timescale 1ns / 1ps
`default_nettype none

//  channel   ports                              direction
//  request   req_valid, req_ready, req_data     in  (bus access or panel event)
//  response  rsp_valid, rsp_ready, rsp_data     out (read data and panel lines)
//
//  One transaction per cycle while responses are taken; a response passes registers s1
//  to s4 and the response register. Register state updates in the accept cycle; the
//  segment digits come from a pipelined decimal split (reciprocal multiplies and compares).
//  Reset: synchronous, active high; LEDs, switches, buttons, IRQ clear, digits show 0000.
//  A stalled response holds its stage; requests keep flowing into empty stages.

module board_io_panel_registers (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire bio_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bio_pkg::rsp_type        rsp_data
);

   logic               accept;
   bio_pkg::entry_type entry;

   assign accept = req_valid && req_ready;

   bio_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .entry  (entry)
   );

   bio_seg_pipe u_seg_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .entry     (entry),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ sv/bio_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bio_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire bio_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire bio_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while response side free");

endmodule

bind board_io_panel_registers bio_checker u_bio_checker (.*);

`default_nettype wire
